// ===== rtl/core/bdtfe_pkg.sv =====
`default_nettype none
package bdtfe_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_INC  = 2'd1,
    CMD_NEXT = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    FLD_HOURS   = 3'd0,
    FLD_MINUTES = 3'd1,
    FLD_YEAR    = 3'd2,
    FLD_MONTH   = 3'd3,
    FLD_DAY     = 3'd4
  } field_t;

  localparam int unsigned DataInW  = 40;
  localparam int unsigned DataOutW = 40;

  localparam logic [7:0] HoursWrap   = 8'd24;
  localparam logic [7:0] MinutesWrap = 8'd60;
  localparam logic [7:0] YearWrap    = 8'd100;
  localparam logic [7:0] MonthWrap   = 8'd13;
  localparam logic [4:0] FebShort    = 5'd28;
  localparam logic [4:0] LongMonth   = 5'd31;

  typedef struct packed {
    logic [5:0] hours;
    logic [6:0] minutes;
    logic       century;
    logic [7:0] year;
    logic [4:0] month;
    logic [5:0] day;
  } load_t;

  typedef struct packed {
    logic       editing;
    field_t     field;
    logic [5:0] hours;
    logic [6:0] minutes;
    logic       century;
    logic [7:0] year;
    logic [4:0] month;
    logic [5:0] day;
  } edit_state_t;

  // packed bcd read as high nibble * 10 + low nibble
  function automatic logic [7:0] bcd_value(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'd0, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
  endfunction

  // values below 100 only; tens by reciprocal multiply
  function automatic logic [7:0] to_bcd(input logic [6:0] d);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 14'(d) * 14'd103;
    tens = prod[13:10];
    ones = d - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] n;
    unique case (m)
      4'd2:                      n = 5'd29;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bdtfe_step.sv =====
`default_nettype none
module bdtfe_step (
  input  wire bdtfe_pkg::edit_state_t cur,
  input  wire logic [1:0]             cmd,
  input  wire bdtfe_pkg::load_t       load,
  output bdtfe_pkg::edit_state_t      nxt,
  output logic                        commit
);

  logic [7:0] hv, mv, yv, mov, dv, mval;
  logic [7:0] h_bcd, mi_bcd, y_bcd, mo_bcd, d_bcd;
  logic       leap;
  logic [4:0] limit;

  always_comb begin
    hv   = bdtfe_pkg::bcd_value({2'd0, cur.hours}) + 8'd1;
    mv   = bdtfe_pkg::bcd_value({1'b0, cur.minutes}) + 8'd1;
    yv   = bdtfe_pkg::bcd_value(cur.year);
    mval = bdtfe_pkg::bcd_value({3'd0, cur.month});
    mov  = mval + 8'd1;
    dv   = bdtfe_pkg::bcd_value({2'd0, cur.day}) + 8'd1;

    h_bcd  = bdtfe_pkg::to_bcd(hv[6:0]);
    mi_bcd = bdtfe_pkg::to_bcd(mv[6:0]);
    y_bcd  = bdtfe_pkg::to_bcd(yv[6:0] + 7'd1);
    mo_bcd = bdtfe_pkg::to_bcd(mov[6:0]);
    d_bcd  = bdtfe_pkg::to_bcd(dv[6:0]);

    // 2000 and 2100 are both multiples of 4; only 2000 is a multiple of 400
    leap = (yv[1:0] == 2'd0) &&
           !(((yv == 8'd0) || (yv == 8'd100)) && !(!cur.century && (yv == 8'd0)));

    if ((mval >= 8'd1) && (mval <= 8'd12)) begin
      limit = bdtfe_pkg::month_days(mval[3:0]);
    end else begin
      limit = bdtfe_pkg::LongMonth;
    end
    if ((mval == 8'd2) && !leap) begin
      limit = bdtfe_pkg::FebShort;
    end

    nxt    = cur;
    commit = 1'b0;

    unique case (bdtfe_pkg::cmd_t'(cmd))
      bdtfe_pkg::CMD_LOAD: begin
        if (!cur.editing) begin
          nxt.editing = 1'b1;
          nxt.field   = bdtfe_pkg::FLD_HOURS;
          nxt.hours   = load.hours;
          nxt.minutes = load.minutes;
          nxt.century = load.century;
          nxt.year    = load.year;
          nxt.month   = load.month;
          nxt.day     = load.day;
        end
      end
      bdtfe_pkg::CMD_INC: begin
        if (cur.editing) begin
          unique case (cur.field)
            bdtfe_pkg::FLD_HOURS: begin
              nxt.hours = (hv >= bdtfe_pkg::HoursWrap) ? 6'd0 : h_bcd[5:0];
            end
            bdtfe_pkg::FLD_MINUTES: begin
              nxt.minutes = (mv >= bdtfe_pkg::MinutesWrap) ? 7'd0 : mi_bcd[6:0];
            end
            bdtfe_pkg::FLD_YEAR: begin
              if ((yv + 8'd1) >= bdtfe_pkg::YearWrap) begin
                nxt.year    = 8'd0;
                nxt.century = !cur.century;
              end else begin
                nxt.year = y_bcd;
              end
            end
            bdtfe_pkg::FLD_MONTH: begin
              nxt.month = (mov >= bdtfe_pkg::MonthWrap) ? 5'd1 : mo_bcd[4:0];
            end
            bdtfe_pkg::FLD_DAY: begin
              nxt.day = (dv > {3'd0, limit}) ? 6'd1 : d_bcd[5:0];
            end
            default: begin
              nxt = cur;
            end
          endcase
        end
      end
      bdtfe_pkg::CMD_NEXT: begin
        if (cur.editing) begin
          if (cur.field == bdtfe_pkg::FLD_DAY) begin
            nxt.editing = 1'b0;
            nxt.field   = bdtfe_pkg::FLD_HOURS;
            commit      = 1'b1;
          end else begin
            nxt.field = bdtfe_pkg::field_t'(cur.field + 3'd1);
          end
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/bcd_date_time_field_editor.sv =====
// Clock-setting editor for a packed BCD date and time. A load transaction
// (tuser 0) copies hours, minutes, century, year, month and day and starts
// editing at the hours field; increment (tuser 1) steps the selected field
// with wrap, days limited by month length and the leap rule; next (tuser 2)
// moves hours, minutes, year, month, day and then ends editing with tlast
// high, meaning the values are to be written with seconds zero. Each input
// transaction gives exactly one output transaction carrying the whole
// setting. One transaction is taken every cycle unless the output stalls;
// an input register is followed by the result register, with the field
// update done combinationally against the held setting.
`default_nettype none
module bcd_date_time_field_editor (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // load_hours, load_minutes, load_century, load_year, load_month, load_day
  input  wire logic [bdtfe_pkg::DataInW-1:0]   in_tdata,
  // command
  input  wire logic [1:0]                      in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // editing, selected_field, hours, minutes, century, year, month, day
  output logic [bdtfe_pkg::DataOutW-1:0]       out_tdata,
  // commit
  output logic                                 out_tlast
);

  logic                   s1_valid_r;
  logic [1:0]             s1_cmd_r;
  bdtfe_pkg::load_t       s1_load_r;
  logic                   s1_adv;
  logic                   in_acc;

  bdtfe_pkg::edit_state_t state_r;
  bdtfe_pkg::edit_state_t state_nxt;
  logic                   commit_nxt;

  logic                   out_valid_r;
  bdtfe_pkg::edit_state_t out_state_r;
  logic                   out_commit_r;

  bdtfe_pkg::load_t       in_load;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign in_load.hours   = in_tdata[5:0];
  assign in_load.minutes = in_tdata[12:6];
  assign in_load.century = in_tdata[13];
  assign in_load.year    = in_tdata[21:14];
  assign in_load.month   = in_tdata[26:22];
  assign in_load.day     = in_tdata[32:27];

  bdtfe_step u_step (
    .cur    (state_r),
    .cmd    (s1_cmd_r),
    .load   (s1_load_r),
    .nxt    (state_nxt),
    .commit (commit_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= in_tuser;
      s1_load_r <= in_load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.editing <= 1'b0;
      state_r.field   <= bdtfe_pkg::FLD_HOURS;
      state_r.hours   <= 6'd0;
      state_r.minutes <= 7'd0;
      state_r.century <= 1'b0;
      state_r.year    <= 8'd0;
      state_r.month   <= 5'd1;
      state_r.day     <= 6'd1;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_state_r  <= state_nxt;
      out_commit_r <= commit_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_commit_r;
  assign out_tdata  = {3'd0,
                       out_state_r.day,
                       out_state_r.month,
                       out_state_r.year,
                       out_state_r.century,
                       out_state_r.minutes,
                       out_state_r.hours,
                       out_state_r.field,
                       out_state_r.editing};

endmodule
`default_nettype wire
